// ----- hw/rtl/jzr_pkg.sv -----
// Shared types, constants and register map for the joystick zone reporter.
package jzr_pkg;

  // Converter sample width.
  localparam int SAMPLE_BITS = 12;
  localparam int SUM_BITS    = SAMPLE_BITS + 2;

  // APB register map, one 32-bit word per register.
  localparam int ADDR_BITS = 4;
  localparam logic [1:0] REG_TERMINAL_MODE = 2'd0;
  localparam logic [1:0] REG_LOW_LIMIT     = 2'd1;
  localparam logic [1:0] REG_HIGH_LIMIT    = 2'd2;
  localparam logic [1:0] REG_REFRESH_LIMIT = 2'd3;

  // Register reset values.
  localparam logic        RST_TERMINAL_MODE = 1'b0;
  localparam logic [11:0] RST_LOW_LIMIT     = 12'd1500;
  localparam logic [11:0] RST_HIGH_LIMIT    = 12'd3000;
  localparam logic [7:0]  RST_REFRESH_LIMIT = 8'd100;

  // Report bytes.
  localparam logic [7:0] CHR_ZERO   = 8'd48;
  localparam logic [7:0] CHR_A      = 8'd65;
  localparam logic [7:0] CHR_S      = 8'd83;
  localparam logic [7:0] CHR_COMMA  = 8'd44;
  localparam logic [7:0] CHR_COLON  = 8'd58;
  localparam logic [7:0] CHR_X      = 8'd88;
  localparam logic [7:0] CHR_Y      = 8'd89;
  localparam logic [7:0] CHR_R      = 8'd82;
  localparam logic [7:0] CHR_C      = 8'd67;
  localparam logic [7:0] CHR_L      = 8'd76;
  localparam logic [7:0] CHR_B      = 8'd66;
  localparam logic [7:0] CHR_T      = 8'd84;
  localparam logic [7:0] CTL_SOH    = 8'd1;
  localparam logic [7:0] CTL_STX    = 8'd2;
  localparam logic [7:0] CTL_FF     = 8'd12;
  localparam logic [7:0] CTL_LF     = 8'd10;
  localparam logic [7:0] CTL_BS     = 8'd8;

  // Report lengths, as last byte index.
  localparam logic [4:0] PKT_LAST_IDX  = 5'd4;
  localparam logic [4:0] TERM_LAST_IDX = 5'd21;

  // Zone codes; ZONE_NONE only appears as the post-reset history.
  typedef enum logic [1:0] {
    ZONE_LOW  = 2'd0,
    ZONE_MID  = 2'd1,
    ZONE_HIGH = 2'd2,
    ZONE_NONE = 2'd3
  } zone_t;

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef sample_t [3:0] sample_quad_t;

  // Input transfer payload.
  typedef struct packed {
    logic [11:0] h_sample_0;
    logic [11:0] h_sample_1;
    logic [11:0] h_sample_2;
    logic [11:0] h_sample_3;
    logic [11:0] v_sample_0;
    logic [11:0] v_sample_1;
    logic [11:0] v_sample_2;
    logic [11:0] v_sample_3;
  } in_item_t;

  // Output transfer payload.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } out_item_t;

  // What one axis lane hands to the merge stage.
  typedef struct packed {
    zone_t      zone;
    logic [3:0] thou;
    logic [3:0] hund;
    logic [6:0] rem;
  } axis_t;

  // One pending report; digit index 3 is the most significant.
  typedef struct packed {
    logic            term;
    zone_t           hz;
    zone_t           vz;
    logic [3:0][3:0] hdig;
    logic [3:0][3:0] vdig;
  } report_t;

endpackage

// ----- hw/rtl/jzr_axis_lane.sv -----
// One axis lane: rounded average, zone class and upper decimal digits.
module jzr_axis_lane (
  input  logic                  clk,
  input  logic                  en1,
  input  logic                  en2,
  input  jzr_pkg::sample_quad_t samples,
  input  logic [11:0]           low_limit,
  input  logic [11:0]           high_limit,
  output jzr_pkg::axis_t        axis
);
  import jzr_pkg::*;

  logic [SUM_BITS-1:0]    sum;
  logic [SAMPLE_BITS-1:0] avg_now;
  zone_t                  zone_now;
  logic [SAMPLE_BITS-1:0] avg;
  zone_t                  zone1;
  logic [3:0]             thou;
  logic [3:0]             hund;
  logic [SAMPLE_BITS-1:0] rem1;
  logic [SAMPLE_BITS-1:0] rem2;

  // Stage 1: rounded average and zone
  always_comb begin
    sum = SUM_BITS'(2);
    for (int i = 0; i < 4; i++) begin
      sum = sum + SUM_BITS'(samples[i]);
    end
    avg_now = sum[SUM_BITS-1:2];
    if (avg_now <= low_limit) begin
      zone_now = ZONE_LOW;
    end else if (avg_now > high_limit) begin
      zone_now = ZONE_HIGH;
    end else begin
      zone_now = ZONE_MID;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      avg   <= avg_now;
      zone1 <= zone_now;
    end
  end

  // Stage 2: thousands and hundreds by parallel compares
  always_comb begin
    thou = 4'd0;
    for (int k = 1; k <= 4; k++) begin
      if (avg >= SAMPLE_BITS'(k * 1000)) thou = 4'(k);
    end
    rem1 = avg - SAMPLE_BITS'(SAMPLE_BITS'(thou) * SAMPLE_BITS'(1000));
    hund = 4'd0;
    for (int k = 1; k <= 9; k++) begin
      if (rem1 >= SAMPLE_BITS'(k * 100)) hund = 4'(k);
    end
    rem2 = rem1 - SAMPLE_BITS'(SAMPLE_BITS'(hund) * SAMPLE_BITS'(100));
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      axis.zone <= zone1;
      axis.thou <= thou;
      axis.hund <= hund;
      axis.rem  <= rem2[6:0];
    end
  end

endmodule

// ----- hw/rtl/jzr_merge.sv -----
// Merge stage: report decision, round counter, zone history, report slot.
module jzr_merge (
  input  logic             clk,
  input  logic             rst,
  input  logic             s2_valid,
  input  jzr_pkg::axis_t   h_axis,
  input  jzr_pkg::axis_t   v_axis,
  input  logic             terminal_mode,
  input  logic [7:0]       refresh_limit,
  input  logic             rep_take,
  output logic             s2_adv,
  output logic             rep_valid,
  output jzr_pkg::report_t rep
);
  import jzr_pkg::*;

  logic [7:0] round_counter;
  logic [7:0] cnt_inc;
  zone_t      prev_h_zone;
  zone_t      prev_v_zone;
  logic       send;
  logic [3:0] h_tens;
  logic [3:0] h_ones;
  logic [3:0] v_tens;
  logic [3:0] v_ones;
  report_t    rep_next;

  // Report decision
  always_comb begin
    cnt_inc = round_counter + 8'd1;
    send    = (cnt_inc > refresh_limit) || (h_axis.zone != prev_h_zone) ||
              (v_axis.zone != prev_v_zone);
    s2_adv  = s2_valid && (!send || !rep_valid || rep_take);
  end

  // Low two digits from the remainder below one hundred
  always_comb begin
    h_tens = 4'd0;
    v_tens = 4'd0;
    for (int k = 1; k <= 9; k++) begin
      if (h_axis.rem >= 7'(k * 10)) h_tens = 4'(k);
      if (v_axis.rem >= 7'(k * 10)) v_tens = 4'(k);
    end
    h_ones = 4'(h_axis.rem - 7'(7'(h_tens) * 7'd10));
    v_ones = 4'(v_axis.rem - 7'(7'(v_tens) * 7'd10));
    rep_next.term = terminal_mode;
    rep_next.hz   = h_axis.zone;
    rep_next.vz   = v_axis.zone;
    rep_next.hdig = {h_axis.thou, h_axis.hund, h_tens, h_ones};
    rep_next.vdig = {v_axis.thou, v_axis.hund, v_tens, v_ones};
  end

  // History and counter
  always_ff @(posedge clk) begin
    if (rst) begin
      round_counter <= 8'd0;
      prev_h_zone   <= ZONE_NONE;
      prev_v_zone   <= ZONE_NONE;
    end else if (s2_adv) begin
      round_counter <= send ? 8'd0 : cnt_inc;
      prev_h_zone   <= h_axis.zone;
      prev_v_zone   <= v_axis.zone;
    end
  end

  // Report slot between the merge and the serializer
  always_ff @(posedge clk) begin
    if (rst) begin
      rep_valid <= 1'b0;
    end else if (s2_adv && send) begin
      rep_valid <= 1'b1;
    end else if (rep_take) begin
      rep_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv && send) begin
      rep <= rep_next;
    end
  end

endmodule

// ----- hw/rtl/jzr_serializer.sv -----
// Byte serializer: walks one report out, one byte per transfer.
module jzr_serializer (
  input  logic               clk,
  input  logic               rst,
  input  logic               rep_valid,
  input  jzr_pkg::report_t   rep,
  output logic               rep_take,
  output logic               out_valid,
  input  logic               out_ready,
  output jzr_pkg::out_item_t out_item
);
  import jzr_pkg::*;

  logic       busy;
  logic [4:0] idx;
  report_t    cur;
  logic [4:0] last_idx;
  logic       done;

  function automatic logic [7:0] digit(input logic [3:0] d);
    digit = CHR_ZERO + {4'd0, d};
  endfunction

  function automatic logic [7:0] h_letter(input zone_t z);
    case (z)
      ZONE_LOW:  h_letter = CHR_R;
      ZONE_MID:  h_letter = CHR_C;
      ZONE_HIGH: h_letter = CHR_L;
      default:   h_letter = CHR_C;
    endcase
  endfunction

  function automatic logic [7:0] v_letter(input zone_t z);
    case (z)
      ZONE_LOW:  v_letter = CHR_B;
      ZONE_MID:  v_letter = CHR_C;
      ZONE_HIGH: v_letter = CHR_T;
      default:   v_letter = CHR_C;
    endcase
  endfunction

  // Handshake
  always_comb begin
    last_idx  = cur.term ? TERM_LAST_IDX : PKT_LAST_IDX;
    out_valid = busy;
    done      = busy && out_ready && (idx == last_idx);
    rep_take  = rep_valid && (!busy || done);
  end

  // Byte select
  always_comb begin
    out_item.last = (idx == last_idx);
    if (cur.term) begin
      case (idx)
        5'd0:    out_item.out_byte = CTL_SOH;
        5'd1:    out_item.out_byte = CTL_STX;
        5'd2:    out_item.out_byte = CTL_FF;
        5'd3:    out_item.out_byte = CHR_X;
        5'd4:    out_item.out_byte = CHR_COLON;
        5'd5:    out_item.out_byte = digit(cur.hdig[3]);
        5'd6:    out_item.out_byte = digit(cur.hdig[2]);
        5'd7:    out_item.out_byte = digit(cur.hdig[1]);
        5'd8:    out_item.out_byte = digit(cur.hdig[0]);
        5'd9:    out_item.out_byte = CTL_LF;
        5'd16:   out_item.out_byte = CHR_Y;
        5'd17:   out_item.out_byte = CHR_COLON;
        5'd18:   out_item.out_byte = digit(cur.vdig[3]);
        5'd19:   out_item.out_byte = digit(cur.vdig[2]);
        5'd20:   out_item.out_byte = digit(cur.vdig[1]);
        5'd21:   out_item.out_byte = digit(cur.vdig[0]);
        default: out_item.out_byte = CTL_BS;
      endcase
    end else begin
      case (idx)
        5'd0:    out_item.out_byte = CHR_A;
        5'd1:    out_item.out_byte = h_letter(cur.hz);
        5'd2:    out_item.out_byte = CHR_COMMA;
        5'd3:    out_item.out_byte = v_letter(cur.vz);
        default: out_item.out_byte = CHR_S;
      endcase
    end
  end

  // Position within the report
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= 5'd0;
    end else if (rep_take) begin
      busy <= 1'b1;
      idx  <= 5'd0;
    end else if (done) begin
      busy <= 1'b0;
    end else if (busy && out_ready) begin
      idx <= idx + 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rep_take) begin
      cur <= rep;
    end
  end

endmodule

// ----- hw/rtl/joystick_zone_reporter_core.sv -----
// Top level of the joystick zone reporter: config registers and pipeline control.
//
//   channel | signals                              | direction
//   --------+--------------------------------------+----------
//   input   | in_valid, in_ready, in_item          | in
//   output  | out_valid, out_ready, out_item       | out
//   config  | psel, penable, pwrite, paddr, pwdata, prdata, pready | APB slave
//
// Two axis lanes run side by side through two stages (average and zone, then
// digits); the merge stage decides on a report and parks it in a one-deep slot.
// A round that reports nothing never waits on the report slot; with no stalls
// a round can be taken every cycle. Each report holds the serializer for 5 or
// 22 bytes, one byte per transfer; the first byte passes the lane, slot and
// serializer registers. Reset clears counter, zone history and all valid flags.
module joystick_zone_reporter_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  jzr_pkg::in_item_t                   in_item,
  output logic                                out_valid,
  input  logic                                out_ready,
  output jzr_pkg::out_item_t                  out_item,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [jzr_pkg::ADDR_BITS-1:0]       paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);
  import jzr_pkg::*;

  logic         terminal_mode;
  logic [11:0]  low_limit;
  logic [11:0]  high_limit;
  logic [7:0]   refresh_limit;
  logic [1:0]   reg_idx;
  logic         wr_en;
  logic         s1_valid;
  logic         s2_valid;
  logic         en1;
  logic         en2;
  logic         s2_adv;
  logic         rep_valid;
  logic         rep_take;
  report_t      rep;
  axis_t        h_axis;
  axis_t        v_axis;
  sample_quad_t h_quad;
  sample_quad_t v_quad;

  // Configuration registers
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      terminal_mode <= RST_TERMINAL_MODE;
      low_limit     <= RST_LOW_LIMIT;
      high_limit    <= RST_HIGH_LIMIT;
      refresh_limit <= RST_REFRESH_LIMIT;
    end else if (wr_en) begin
      case (reg_idx)
        REG_TERMINAL_MODE: terminal_mode <= pwdata[0];
        REG_LOW_LIMIT:     low_limit     <= pwdata[11:0];
        REG_HIGH_LIMIT:    high_limit    <= pwdata[11:0];
        REG_REFRESH_LIMIT: refresh_limit <= pwdata[7:0];
        default:           ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_TERMINAL_MODE: prdata = {31'd0, terminal_mode};
      REG_LOW_LIMIT:     prdata = {20'd0, low_limit};
      REG_HIGH_LIMIT:    prdata = {20'd0, high_limit};
      REG_REFRESH_LIMIT: prdata = {24'd0, refresh_limit};
      default:           prdata = 32'd0;
    endcase
  end

  // Pipeline advance: a stage loads when it is empty or its item moves on
  assign en2      = !s2_valid || s2_adv;
  assign in_ready = !s1_valid || en2;
  assign en1      = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (in_ready) s1_valid <= in_valid;
      if (en2)      s2_valid <= s1_valid;
    end
  end

  assign h_quad = {in_item.h_sample_3, in_item.h_sample_2,
                   in_item.h_sample_1, in_item.h_sample_0};
  assign v_quad = {in_item.v_sample_3, in_item.v_sample_2,
                   in_item.v_sample_1, in_item.v_sample_0};

  // Axis lanes
  jzr_axis_lane u_h_lane (
    .clk        (clk),
    .en1        (en1),
    .en2        (en2),
    .samples    (h_quad),
    .low_limit  (low_limit),
    .high_limit (high_limit),
    .axis       (h_axis)
  );

  jzr_axis_lane u_v_lane (
    .clk        (clk),
    .en1        (en1),
    .en2        (en2),
    .samples    (v_quad),
    .low_limit  (low_limit),
    .high_limit (high_limit),
    .axis       (v_axis)
  );

  // Merge and report slot
  jzr_merge u_merge (
    .clk           (clk),
    .rst           (rst),
    .s2_valid      (s2_valid),
    .h_axis        (h_axis),
    .v_axis        (v_axis),
    .terminal_mode (terminal_mode),
    .refresh_limit (refresh_limit),
    .rep_take      (rep_take),
    .s2_adv        (s2_adv),
    .rep_valid     (rep_valid),
    .rep           (rep)
  );

  // Byte output
  jzr_serializer u_ser (
    .clk       (clk),
    .rst       (rst),
    .rep_valid (rep_valid),
    .rep       (rep),
    .rep_take  (rep_take),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule
